### src/rlc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and prefix tables for the response line classifier.
package rlc_pkg;

   localparam int RLC_STORE_DEPTH = 128;
   localparam int RLC_PREFIX_COUNT = 4;

   localparam logic [1:0] ACT_RECEIVE = 2'd0;
   localparam logic [1:0] ACT_CLEAR   = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] rx_byte;
      logic [6:0] read_index;
   } rlc_req_type;

   typedef struct packed {
      logic [2:0] ready_bits;
      logic [7:0] fill_count;
      logic [7:0] read_byte;
   } rlc_rsp_type;

   // Per-request result info from the line control to the response pipeline.
   typedef struct packed {
      logic [2:0] ready_bits;
      logic [7:0] fill_count;
      logic       read_hit;
   } rlc_step_type;

   // Common 9-character lead-in shared by all prefixes.
   localparam logic [8:0][7:0] LEAD_TEXT = {
      8'h2C, 8'h44, 8'h49, 8'h46, 8'h52, 8'h53, 8'h56, 8'h44, 8'h24
   };

   function automatic logic [3:0] prefix_len(input logic [1:0] k);
      logic [3:0] len;
      unique case (k)
         2'd0:    len = 4'd13;
         2'd1:    len = 4'd14;
         2'd2:    len = 4'd13;
         default: len = 4'd12;
      endcase
      return len;
   endfunction

   function automatic logic [2:0] prefix_flag(input logic [1:0] k);
      logic [2:0] flag;
      unique case (k)
         2'd0, 2'd1: flag = 3'b001;
         2'd2:       flag = 3'b010;
         default:    flag = 3'b100;
      endcase
      return flag;
   endfunction

   // Character of prefix k at position pos; zero past the end.
   function automatic logic [7:0] prefix_char(input logic [1:0] k, input logic [3:0] pos);
      logic [4:0][7:0] tail;
      logic [7:0]      ch;
      unique case (k)
         2'd0:    tail = {8'h00, 8'h2C, 8'h59, 8'h44, 8'h52};
         2'd1:    tail = {8'h2C, 8'h44, 8'h41, 8'h45, 8'h52};
         2'd2:    tail = {8'h00, 8'h2C, 8'h52, 8'h45, 8'h56};
         default: tail = {8'h00, 8'h00, 8'h44, 8'h45, 8'h4C};
      endcase
      if (pos < 4'd9) begin
         ch = LEAD_TEXT[pos];
      end else if (pos < 4'd14) begin
         ch = tail[3'(pos - 4'd9)];
      end else begin
         ch = 8'h00;
      end
      return ch;
   endfunction

endpackage

### src/reader_response_line_classifier_unit.sv
`timescale 1ns / 1ps
// Top level of the reader response line classifier.
//
// Requests arrive on req_valid/req_ready/req_data: receive a UART byte, clear
// the fill count and flags, or read a stored byte. Each request yields exactly
// one response on rsp_valid/rsp_ready/rsp_data with the ready flags and fill
// count after the request and, for a read, the stored byte (zero at or past
// the fill count).
// An accepted request is registered in the read stage, then moves into the
// response register when that is empty or being taken. Throughput: one
// request per cycle unless the response stalls; the store is a single RAM
// written at the fill position and read at the request index, one access each
// per cycle, with the read data registered in the RAM for the response stage.
// Reset clears the fill count and flags and re-arms all prefix trackers; the
// store contents are not cleared and need no sweep.
// When the receiver stalls, the response register and one stage behind it
// fill up, after which req_ready drops until rsp_ready returns.
module reader_response_line_classifier_unit
   import rlc_pkg::*;
#(
   parameter int STORE_DEPTH = RLC_STORE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  rlc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rlc_rsp_type rsp_data
);

   localparam int AW = $clog2(STORE_DEPTH);

   logic          accept;
   rlc_step_type  step;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   logic          s1_valid_ff, s1_valid_in;
   rlc_step_type  s1_step_ff, s1_step_in;
   logic          out_valid_ff, out_valid_in;
   rlc_rsp_type   rsp_ff, rsp_in;
   logic          s1_adv;

   rlc_line_ctrl #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_line_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .step   (step),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr)
   );

   rlc_ram #(
      .WIDTH(8),
      .DEPTH(STORE_DEPTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign s1_adv    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
      s1_step_in   = accept ? step : s1_step_ff;
      out_valid_in = s1_adv || (out_valid_ff && !rsp_ready);
      rsp_in       = rsp_ff;
      if (s1_adv) begin
         rsp_in.ready_bits = s1_step_ff.ready_bits;
         rsp_in.fill_count = s1_step_ff.fill_count;
         rsp_in.read_byte  = s1_step_ff.read_hit ? rd_data : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_step_ff <= s1_step_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   // no new request while the read stage is blocked
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> !accept)
      else $error("request accepted while read stage stalled");

   // flags are exclusive: once one is set, bytes are ignored until clear
   a_flags_onehot0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_data.ready_bits))
      else $error("more than one ready flag set");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.action == ACT_CLEAR)) |=>
         ((s1_step_ff.fill_count == 8'h00) && (s1_step_ff.ready_bits == 3'b000)))
      else $error("clear did not zero fill count and flags");

   a_rd_hit_needs_read: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (accept && (req_data.action == ACT_READ)))
      else $error("store read without a read request");

endmodule

### src/rlc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module rlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/rlc_line_ctrl.sv
`timescale 1ns / 1ps
// Line control: fill count, prefix tracking, ready flags and store access.
module rlc_line_ctrl
   import rlc_pkg::*;
#(
   parameter int STORE_DEPTH = RLC_STORE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  rlc_req_type                    req,
   output rlc_step_type                   step,
   output logic                           wr_en,
   output logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
   output logic [7:0]                     wr_data,
   output logic                           rd_en,
   output logic [$clog2(STORE_DEPTH)-1:0] rd_addr
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int FW = $clog2(STORE_DEPTH + 1);
   localparam int CW = (FW > 8) ? FW : 8;

   logic [FW-1:0] fill_ff, fill_in;
   logic [2:0]    flags_ff, flags_in;
   logic [3:0]    alive_ff, alive_in;
   logic          full;
   logic          term;
   logic          hit;
   logic [CW-1:0] idx_ext;
   logic [CW-1:0] fill_ext;
   logic [CW-1:0] fill_next_ext;

   assign full          = (fill_ff == FW'(STORE_DEPTH));
   assign term          = (req.rx_byte == CHAR_CR) || (req.rx_byte == CHAR_LF);
   assign idx_ext       = CW'(req.read_index);
   assign fill_ext      = CW'(fill_ff);
   assign fill_next_ext = CW'(fill_in);
   assign hit           = (idx_ext < fill_ext);

   always_comb begin
      fill_in  = fill_ff;
      flags_in = flags_ff;
      alive_in = alive_ff;
      wr_en    = 1'b0;
      if (accept) begin
         unique case (req.action)
            ACT_RECEIVE: begin
               if (!full && (flags_ff == 3'b000)) begin
                  if (term) begin
                     priority if (alive_ff[0] && (fill_ff >= FW'(prefix_len(2'd0)))) begin
                        flags_in = flags_ff | prefix_flag(2'd0);
                     end else if (alive_ff[1] && (fill_ff >= FW'(prefix_len(2'd1)))) begin
                        flags_in = flags_ff | prefix_flag(2'd1);
                     end else if (alive_ff[2] && (fill_ff >= FW'(prefix_len(2'd2)))) begin
                        flags_in = flags_ff | prefix_flag(2'd2);
                     end else if (alive_ff[3] && (fill_ff >= FW'(prefix_len(2'd3)))) begin
                        flags_in = flags_ff | prefix_flag(2'd3);
                     end
                  end else begin
                     for (int k = 0; k < RLC_PREFIX_COUNT; k++) begin
                        if ((fill_ff < FW'(prefix_len(2'(k)))) &&
                            (prefix_char(2'(k), fill_ff[3:0]) != req.rx_byte)) begin
                           alive_in[k] = 1'b0;
                        end
                     end
                     wr_en   = 1'b1;
                     fill_in = fill_ff + FW'(1);
                  end
               end
            end
            ACT_CLEAR: begin
               fill_in  = '0;
               flags_in = '0;
               alive_in = '1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         flags_ff <= '0;
         alive_ff <= '1;
      end else begin
         fill_ff  <= fill_in;
         flags_ff <= flags_in;
         alive_ff <= alive_in;
      end
   end

   assign wr_addr = fill_ff[AW-1:0];
   assign wr_data = req.rx_byte;
   assign rd_en   = accept && (req.action == ACT_READ) && hit;
   assign rd_addr = idx_ext[AW-1:0];

   assign step.ready_bits = flags_in;
   assign step.fill_count = fill_next_ext[7:0];
   assign step.read_hit   = (req.action == ACT_READ) && hit;

endmodule
